[sv/ptts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 16;
  localparam int unsigned RING_DEPTH_DEF = 16;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TALLY_W = 5;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_ENABLE  = 3'd2,
    MODE_DISABLE = 3'd3,
    MODE_TICK    = 3'd4,
    MODE_DEQUEUE = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_RANGE  = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_QEMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] countdown;
    logic             active;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic act_we;
    logic act_val;
  } cell_ctrl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

`default_nettype wire

[sv/ptts_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One table slot. Shifts towards slot 0 during a tick sweep.
module ptts_cell
  import ptts_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      nb_i,
  input  slot_t      load_i,
  output slot_t      slot_o
);

  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.shift) begin
      slot_d = nb_i;
    end else if (ctrl_i.load) begin
      slot_d = load_i;
    end else if (ctrl_i.act_we) begin
      slot_d.active = ctrl_i.act_val;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

[sv/ptts_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ready ring; one entry always kept free. Head entry read every cycle.
module ptts_ring
  import ptts_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  ring_ctrl_t      ctrl_i,
  input  wire [ID_W-1:0]  push_id_i,
  output ring_stat_t      stat_o,
  output logic [ID_W-1:0] head_id_o
);

  localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [RW-1:0] LAST = RW'(RING_DEPTH - 1);

  logic [ID_W-1:0] mem [RING_DEPTH];
  logic [RW-1:0]   head_q, head_d, tail_q, tail_d, tail_nx;
  logic [ID_W-1:0] rd_q;

  assign tail_nx     = (tail_q == LAST) ? '0 : tail_q + RW'(1);
  assign stat_o.full  = (tail_nx == head_q);
  assign stat_o.empty = (tail_q == head_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.push) begin
      tail_d = tail_nx;
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == LAST) ? '0 : head_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    rd_q <= mem[head_q];
  end

  assign head_id_o = rd_q;

endmodule

`default_nettype wire

[sv/periodic_task_tick_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Periodic task scheduler: a table of countdown tasks and a ready ring of ids.
// Input beats arrive on s_axis_*; tuser carries the mode (push, pop, enable,
// disable, tick, dequeue), tdata the operands. Every input beat yields exactly
// one result beat on m_axis_*; tuser carries the status code, tdata the
// result fields.
// Push, pop, enable, disable, dequeue and unused modes go from accept
// straight to the finish state, which loads the output register. A tick
// first runs a sweep state before the finish state: the table is a row of
// slot cells that rotates by one cell per cycle, so every slot passes the
// single read-modify-write unit at cell 0 once, in slot order, and lands
// back in its own cell at the end of the sweep. Fired ids go into the ring
// at most one per cycle during the sweep; an id that finds the ring full is
// dropped and counted.
// One item is in flight at a time; s_axis_tready is high while idle.
// The result sits in an output register: the next input beat is taken while
// it waits, but that item cannot finish until the receiver has taken the
// earlier result, so a stalled receiver stalls the block after one beat.
// Reset (rst_ni low, asynchronous) empties the table and the ring and puts
// the scheduler to sleep; table and ring contents themselves are not cleared.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] task_id, [31:8] period, [55:32] start_count, [56] start_active,
  // [60:57] slot_index, [84:61] elapsed_ticks, [87:85] zero
  input  wire  [87:0] s_axis_tdata,
  // [2:0] mode
  input  wire  [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [3:0] result_slot, [11:4] ready_id, [16:12] fired_count,
  // [21:17] dropped_count, [22] awake, [23] zero
  output logic [23:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);

  // count width holds 0..TASK_SLOTS; compare width also covers slot_index
  localparam int unsigned CW   = $clog2(TASK_SLOTS + 1);
  localparam int unsigned CMPW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(TASK_SLOTS);
  localparam logic [CW-1:0] LAST_K   = CW'(TASK_SLOTS - 1);

  state_e state_q, state_d;

  // latched input beat
  mode_e              mode_q, mode_d;
  slot_t              push_q, push_d;
  logic [SLOT_W-1:0]  sidx_q, sidx_d;
  logic [CNT_W-1:0]   el_q, el_d;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      k_q, k_d;
  logic [TALLY_W-1:0] fired_q, fired_d, drop_q, drop_d;
  logic               awake_q, awake_d;

  // output register
  logic               mv_q, mv_d;
  status_e            mst_q, mst_d;
  logic [SLOT_W-1:0]  mslot_q, mslot_d;
  logic [ID_W-1:0]    mid_q, mid_d;
  logic [TALLY_W-1:0] mfired_q, mfired_d, mdrop_q, mdrop_d;

  slot_t      cell_q  [TASK_SLOTS];
  slot_t      cell_nb [TASK_SLOTS];
  cell_ctrl_t cctrl   [TASK_SLOTS];

  ring_ctrl_t      rctrl;
  ring_stat_t      rstat;
  logic [ID_W-1:0] rhead;

  logic  s_acc, out_free, fin_go, hit, fire;
  slot_t proc;
  logic [CMPW-1:0] cnt_ext, idx_ext;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign fin_go   = (state_q == S_FIN) && out_free;
  assign cnt_ext  = CMPW'(count_q);
  assign idx_ext  = CMPW'(sidx_q);

  // read-modify-write unit at cell 0
  assign hit  = (state_q == S_TICK) && (k_q < count_q) && cell_q[0].active;
  assign fire = el_q >= cell_q[0].countdown;

  always_comb begin
    proc = cell_q[0];
    if (hit) begin
      proc.countdown = fire ? cell_q[0].period : cell_q[0].countdown - el_q;
    end
  end

  assign rctrl.push = hit && fire && !rstat.full;
  assign rctrl.pop  = fin_go && (mode_q == MODE_DEQUEUE) && !rstat.empty;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    if (i == TASK_SLOTS - 1) begin : g_tail
      assign cell_nb[i] = proc;
    end else begin : g_mid
      assign cell_nb[i] = cell_q[i+1];
    end

    assign cctrl[i].shift   = (state_q == S_TICK);
    assign cctrl[i].load    = fin_go && (mode_q == MODE_PUSH) && (count_q != FULL_CNT)
                              && (count_q == CW'(i));
    assign cctrl[i].act_we  = fin_go && ((mode_q == MODE_ENABLE) || (mode_q == MODE_DISABLE))
                              && (idx_ext < cnt_ext) && (idx_ext == CMPW'(i));
    assign cctrl[i].act_val = (mode_q == MODE_ENABLE);

    ptts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctrl[i]),
      .nb_i   (cell_nb[i]),
      .load_i (push_q),
      .slot_o (cell_q[i])
    );
  end

  ptts_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (rctrl),
    .push_id_i (cell_q[0].id),
    .stat_o    (rstat),
    .head_id_o (rhead)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      awake_q <= 1'b0;
      mv_q    <= 1'b0;
      k_q     <= '0;
      fired_q <= '0;
      drop_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      awake_q <= awake_d;
      mv_q    <= mv_d;
      k_q     <= k_d;
      fired_q <= fired_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    push_q   <= push_d;
    sidx_q   <= sidx_d;
    el_q     <= el_d;
    mst_q    <= mst_d;
    mslot_q  <= mslot_d;
    mid_q    <= mid_d;
    mfired_q <= mfired_d;
    mdrop_q  <= mdrop_d;
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    push_d   = push_q;
    sidx_d   = sidx_q;
    el_d     = el_q;
    count_d  = count_q;
    k_d      = k_q;
    fired_d  = fired_q;
    drop_d   = drop_q;
    awake_d  = awake_q;
    mv_d     = mv_q && !m_axis_tready;
    mst_d    = mst_q;
    mslot_d  = mslot_q;
    mid_d    = mid_q;
    mfired_d = mfired_q;
    mdrop_d  = mdrop_q;
    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          mode_d           = mode_e'(s_axis_tuser);
          push_d.id        = s_axis_tdata[7:0];
          push_d.period    = s_axis_tdata[31:8];
          push_d.countdown = s_axis_tdata[55:32];
          push_d.active    = s_axis_tdata[56];
          sidx_d           = s_axis_tdata[60:57];
          el_d             = s_axis_tdata[84:61];
          k_d              = '0;
          fired_d          = '0;
          drop_d           = '0;
          state_d = (mode_e'(s_axis_tuser) == MODE_TICK) ? S_TICK : S_FIN;
        end
      end
      S_TICK: begin
        if (hit && fire) begin
          if (fired_q != TALLY_MAX) begin
            fired_d = fired_q + TALLY_W'(1);
          end
          if (rstat.full && (drop_q != TALLY_MAX)) begin
            drop_d = drop_q + TALLY_W'(1);
          end
        end
        k_d = k_q + CW'(1);
        if (k_q == LAST_K) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          mv_d     = 1'b1;
          mst_d    = STAT_OK;
          mslot_d  = '0;
          mid_d    = '0;
          mfired_d = '0;
          mdrop_d  = '0;
          state_d  = S_IDLE;
          case (mode_q)
            MODE_PUSH: begin
              if (count_q != FULL_CNT) begin
                mslot_d = cnt_ext[SLOT_W-1:0];
                count_d = count_q + CW'(1);
              end else begin
                mst_d = STAT_FULL;
              end
            end
            MODE_POP: begin
              if (count_q != '0) begin
                count_d = count_q - CW'(1);
              end else begin
                mst_d = STAT_EMPTY;
              end
            end
            MODE_ENABLE, MODE_DISABLE: begin
              if (!(idx_ext < cnt_ext)) begin
                mst_d = STAT_RANGE;
              end
            end
            MODE_TICK: begin
              mfired_d = fired_q;
              mdrop_d  = drop_q;
              if (fired_q != '0) begin
                awake_d = 1'b1;
              end
            end
            MODE_DEQUEUE: begin
              if (rstat.empty) begin
                mst_d   = STAT_QEMPTY;
                awake_d = 1'b0;
              end else begin
                mid_d = rhead;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = mst_q;
  assign m_axis_tdata  = {1'b0, awake_q, mdrop_q, mfired_q, mid_q, mslot_q};

endmodule

`default_nettype wire
